### sv/rbpm_pkg.sv
// Shared types and constants for the reference-counted block pool manager.
`default_nettype none
package rbpm_pkg;

  localparam int POOL_BLOCKS_DEF = 128;
  localparam int BLOCK_BYTES_DEF = 256;
  localparam int COUNT_BITS_DEF  = 8;

  localparam int IDX_W   = 7;
  localparam int SIZE_W  = 13;
  localparam int TOTAL_W = 8;
  localparam int GROUP_W = 16;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_ACQUIRE = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_SIZE   = 3'd1,
    STAT_EXHAUSTED  = 3'd2,
    STAT_BAD_HANDLE = 3'd3,
    STAT_NOT_IN_USE = 3'd4,
    STAT_COUNT_ERR  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BST_FREE    = 2'd0,
    BST_ALLOC   = 2'd1,
    BST_SHARED  = 2'd2,
    BST_INVALID = 2'd3
  } bstate_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  request_size;
    logic [31:0]  handle;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [31:0]         result_handle;
    logic [IDX_W-1:0]    block_index;
    logic [SIZE_W-1:0]   block_size;
    logic                handle_valid;
    logic [TOTAL_W-1:0]  active_blocks;
    logic [TOTAL_W-1:0]  peak_blocks;
    logic [TOTAL_W-1:0]  free_blocks;
  } out_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
  } search_t;

endpackage
`default_nettype wire

### sv/rbpm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/rbpm_free_search.sv
// Two-stage lowest-free-block search over the free bitmap.
`default_nettype none
module rbpm_free_search #(
  parameter int POOL_BLOCKS = rbpm_pkg::POOL_BLOCKS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   load,
  input  wire logic [POOL_BLOCKS-1:0] free_map,
  output rbpm_pkg::search_t           result
);

  localparam int NG = (POOL_BLOCKS + rbpm_pkg::GROUP_W - 1) / rbpm_pkg::GROUP_W;
  localparam int PAD_W = NG * rbpm_pkg::GROUP_W;

  logic [PAD_W-1:0] padded;
  logic [NG-1:0]    any_r;
  logic [3:0]       off_r [NG];

  function automatic logic [3:0] lowest16(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  assign padded = PAD_W'(free_map);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NG; g++) begin
        any_r[g] <= |padded[g*rbpm_pkg::GROUP_W +: rbpm_pkg::GROUP_W];
        off_r[g] <= lowest16(padded[g*rbpm_pkg::GROUP_W +: rbpm_pkg::GROUP_W]);
      end
    end
  end

  always_comb begin
    result.found = 1'b0;
    result.idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (any_r[g]) begin
        result.found = 1'b1;
        result.idx   = rbpm_pkg::IDX_W'(g * rbpm_pkg::GROUP_W) +
                       rbpm_pkg::IDX_W'(off_r[g]);
      end
    end
  end

endmodule
`default_nettype wire

### sv/refcounted_block_pool_manager.sv
// Top level of the reference-counted fixed-block buffer pool manager.
// Requests enter on in_valid/in_ready with in_data (kind, request_size,
// handle); each request produces exactly one result on out_valid/out_ready
// with out_data (status, handle, index, size, validity and pool counts).
// A request is handled in two states: the accept edge reads the block entry RAM
// and registers the first free-search stage; the execute state resolves the
// lowest free block, writes the entry back and loads the result register. As
// each request read-modify-writes the entry RAM, a new one is accepted only
// after the current one leaves its execute state. The result register lets the
// next request be accepted while a result waits; if the receiver holds out_ready
// low, the second request waits in its execute state until the result register
// empties. Reset is synchronous on rst_n: the pool is all free at once (a
// per-block free bitmap in flops marks entries that read as free, count zero,
// full block size), active and peak counts clear, and no clearing pass is needed.
`default_nettype none
module refcounted_block_pool_manager #(
  parameter int POOL_BLOCKS = rbpm_pkg::POOL_BLOCKS_DEF,
  parameter int BLOCK_BYTES = rbpm_pkg::BLOCK_BYTES_DEF,
  parameter int COUNT_BITS  = rbpm_pkg::COUNT_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rbpm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rbpm_pkg::out_t      out_data
);

  localparam int IW      = POOL_BLOCKS > 1 ? $clog2(POOL_BLOCKS) : 1;
  localparam int SW      = rbpm_pkg::SIZE_W;
  localparam int TW      = rbpm_pkg::TOTAL_W;
  localparam int ENTRY_W = 2 + COUNT_BITS + SW;

  typedef enum logic {S_IDLE, S_EXEC} fsm_t;

  fsm_t                   state_r, state_nxt;
  logic [POOL_BLOCKS-1:0] free_map_r;
  logic [TW-1:0]          active_r, active_nxt;
  logic [TW-1:0]          peak_r, peak_nxt;
  logic                   out_valid_r;
  rbpm_pkg::out_t         out_data_r, out_nxt;

  rbpm_pkg::kind_t        kind_r;
  logic [15:0]            size_r;
  logic [IW-1:0]          hidx_r;
  logic                   hbad_r;

  logic                   in_fire, exec_fire, hbad_in;
  logic [15:0]            h_lo;
  rbpm_pkg::search_t      search;

  logic [ENTRY_W-1:0]     ram_rdata, ram_wdata;
  logic                   ram_we;
  logic                   free_hit;
  rbpm_pkg::bstate_t      st, nst;
  logic [COUNT_BITS-1:0]  cnt, ncnt;
  logic [SW-1:0]          sz, nsz;
  logic [IW-1:0]          idx;
  logic                   has_idx, in_use, free_set, free_clr;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign h_lo    = in_data.handle[15:0];
  assign hbad_in = (in_data.handle == 32'd0) ||
                   (in_data.handle[31:16] != ~h_lo) ||
                   (h_lo >= 16'(POOL_BLOCKS));

  rbpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_BLOCKS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_data.handle[IW-1:0]),
    .rdata (ram_rdata)
  );

  rbpm_free_search #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_free_search (
    .clk      (clk),
    .load     (in_fire),
    .free_map (free_map_r),
    .result   (search)
  );

  assign free_hit = free_map_r[hidx_r];

  always_comb begin
    if (free_hit) begin
      st  = rbpm_pkg::BST_FREE;
      cnt = '0;
      sz  = SW'(BLOCK_BYTES);
    end else begin
      st  = rbpm_pkg::bstate_t'(ram_rdata[ENTRY_W-1 -: 2]);
      cnt = ram_rdata[SW +: COUNT_BITS];
      sz  = ram_rdata[SW-1:0];
    end
  end

  always_comb begin
    out_nxt               = '0;
    out_nxt.status        = rbpm_pkg::STAT_OK;
    has_idx               = 1'b0;
    idx                   = hidx_r;
    nst                   = st;
    ncnt                  = cnt;
    nsz                   = sz;
    ram_we                = 1'b0;
    free_set              = 1'b0;
    free_clr              = 1'b0;
    active_nxt            = active_r;
    peak_nxt              = peak_r;
    state_nxt             = state_r;

    case (kind_r)
      rbpm_pkg::KIND_ALLOC: begin
        if (size_r == 16'd0 || size_r > 16'(BLOCK_BYTES)) begin
          out_nxt.status = rbpm_pkg::STAT_BAD_SIZE;
        end else if (!search.found) begin
          out_nxt.status = rbpm_pkg::STAT_EXHAUSTED;
        end else begin
          has_idx  = 1'b1;
          idx      = search.idx[IW-1:0];
          nst      = rbpm_pkg::BST_ALLOC;
          ncnt     = COUNT_BITS'(1);
          nsz      = SW'(size_r);
          ram_we   = exec_fire;
          free_clr = 1'b1;
          if (active_r != {TW{1'b1}}) begin
            active_nxt = active_r + TW'(1);
          end
          out_nxt.result_handle = {~16'(idx), 16'(idx)};
        end
      end
      default: begin
        if (hbad_r) begin
          out_nxt.status = rbpm_pkg::STAT_BAD_HANDLE;
        end else begin
          has_idx = 1'b1;
          in_use  = (st == rbpm_pkg::BST_ALLOC) || (st == rbpm_pkg::BST_SHARED);
          case (kind_r)
            rbpm_pkg::KIND_ACQUIRE: begin
              if (!in_use) begin
                out_nxt.status = rbpm_pkg::STAT_NOT_IN_USE;
              end else if (cnt == {COUNT_BITS{1'b1}}) begin
                out_nxt.status = rbpm_pkg::STAT_COUNT_ERR;
              end else begin
                ncnt   = cnt + COUNT_BITS'(1);
                ram_we = exec_fire;
                if (cnt == COUNT_BITS'(1)) begin
                  nst = rbpm_pkg::BST_SHARED;
                end
              end
            end
            rbpm_pkg::KIND_RELEASE: begin
              if (!in_use) begin
                out_nxt.status = rbpm_pkg::STAT_NOT_IN_USE;
              end else if (cnt == '0) begin
                nst            = rbpm_pkg::BST_INVALID;
                ram_we         = exec_fire;
                out_nxt.status = rbpm_pkg::STAT_COUNT_ERR;
              end else begin
                ncnt   = cnt - COUNT_BITS'(1);
                ram_we = exec_fire;
                if (cnt == COUNT_BITS'(1)) begin
                  nst      = rbpm_pkg::BST_FREE;
                  nsz      = SW'(BLOCK_BYTES);
                  free_set = 1'b1;
                  if (active_r != '0) begin
                    active_nxt = active_r - TW'(1);
                  end
                end else if (cnt == COUNT_BITS'(2)) begin
                  nst = rbpm_pkg::BST_ALLOC;
                end
              end
            end
            default: begin
              if (!in_use) begin
                out_nxt.status = rbpm_pkg::STAT_NOT_IN_USE;
              end else if (cnt == '0) begin
                out_nxt.status = rbpm_pkg::STAT_COUNT_ERR;
              end
            end
          endcase
        end
      end
    endcase

    if (active_nxt > peak_r) begin
      peak_nxt = active_nxt;
    end

    in_use = (nst == rbpm_pkg::BST_ALLOC) || (nst == rbpm_pkg::BST_SHARED);
    if (has_idx) begin
      out_nxt.block_index  = rbpm_pkg::IDX_W'(idx);
      out_nxt.block_size   = in_use ? nsz : '0;
      out_nxt.handle_valid = in_use && (ncnt != '0);
    end
    out_nxt.active_blocks = active_nxt;
    out_nxt.peak_blocks   = peak_nxt;
    out_nxt.free_blocks   = (active_nxt >= TW'(POOL_BLOCKS)) ? '0
                            : TW'(POOL_BLOCKS) - active_nxt;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_wdata = {nst, ncnt, nsz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_map_r  <= '1;
      active_r    <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        kind_r <= in_data.kind;
        size_r <= in_data.request_size;
        hidx_r <= in_data.handle[IW-1:0];
        hbad_r <= hbad_in;
      end
      if (exec_fire) begin
        active_r    <= active_nxt;
        peak_r      <= peak_nxt;
        out_data_r  <= out_nxt;
        out_valid_r <= 1'b1;
        if (free_clr) begin
          free_map_r[idx] <= 1'b0;
        end
        if (free_set) begin
          free_map_r[idx] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### tb/tb_refcounted_block_pool_manager.sv
// Self-checking testbench for the reference-counted block pool manager.
module tb_refcounted_block_pool_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import rbpm_pkg::*;

  localparam int NBLK    = POOL_BLOCKS_DEF;
  localparam int BYTES   = BLOCK_BYTES_DEF;
  localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;
  localparam int LIMIT   = 200000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic in_fire = 1'b0;
  logic hold_go = 1'b0;
  logic hold_rx = 1'b0;
  int   send_idle;
  int   recv_idle;
  int   err_n = 0;
  int   cyc_n = 0;
  int   n_in  = 0;
  int   n_out = 0;
  int   stat_seen [6];

  in_t  req_q  [$];
  out_t pend_q [$];

  bstate_t          pool_st   [NBLK];
  logic [7:0]       pool_cnt  [NBLK];
  logic [SIZE_W-1:0] pool_sz  [NBLK];
  int unsigned      pool_active;
  int unsigned      pool_peak;

  int  gen_cnt [NBLK];
  bit  fill_mode;

  refcounted_block_pool_manager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] mk_handle(int unsigned idx);
    logic [15:0] lo;
    lo = idx[15:0];
    return {lo ^ 16'hFFFF, lo};
  endfunction

  function automatic in_t mk_req(kind_t k, logic [15:0] sz, logic [31:0] h);
    in_t r;
    r.kind = k;
    r.request_size = sz;
    r.handle = h;
    return r;
  endfunction

  function automatic bit blk_in_use(int idx);
    return pool_st[idx] == BST_ALLOC || pool_st[idx] == BST_SHARED;
  endfunction

  function automatic out_t pool_apply(in_t r);
    out_t o;
    int idx;
    int i;
    logic [15:0] lo;
    o = '0;
    o.status = STAT_OK;
    idx = -1;
    lo = r.handle[15:0];
    if (r.kind == KIND_ALLOC) begin
      if (r.request_size == 0 || r.request_size > BYTES) begin
        o.status = STAT_BAD_SIZE;
      end else begin
        for (i = 0; i < NBLK; i++) begin
          if (idx < 0 && pool_st[i] == BST_FREE) idx = i;
        end
        if (idx < 0) begin
          o.status = STAT_EXHAUSTED;
        end else begin
          pool_sz[idx] = r.request_size[SIZE_W-1:0];
          pool_cnt[idx] = 8'd1;
          pool_st[idx] = BST_ALLOC;
          if (pool_active < 255) pool_active++;
          if (pool_active > pool_peak) pool_peak = pool_active;
          o.result_handle = mk_handle(idx);
        end
      end
    end else if (r.handle == 32'h0 || r.handle[31:16] != (lo ^ 16'hFFFF) || lo >= NBLK) begin
      o.status = STAT_BAD_HANDLE;
    end else begin
      idx = int'(lo);
      case (r.kind)
        KIND_ACQUIRE: begin
          if (!blk_in_use(idx)) begin
            o.status = STAT_NOT_IN_USE;
          end else if (pool_cnt[idx] >= CNT_MAX) begin
            o.status = STAT_COUNT_ERR;
          end else begin
            if (pool_cnt[idx] == 8'd1) pool_st[idx] = BST_SHARED;
            pool_cnt[idx] = pool_cnt[idx] + 8'd1;
          end
        end
        KIND_RELEASE: begin
          if (!blk_in_use(idx)) begin
            o.status = STAT_NOT_IN_USE;
          end else if (pool_cnt[idx] == 8'd0) begin
            pool_st[idx] = BST_INVALID;
            o.status = STAT_COUNT_ERR;
          end else begin
            pool_cnt[idx] = pool_cnt[idx] - 8'd1;
            if (pool_cnt[idx] == 8'd0) begin
              pool_st[idx] = BST_FREE;
              pool_sz[idx] = SIZE_W'(BYTES);
              if (pool_active > 0) pool_active--;
            end else if (pool_cnt[idx] == 8'd1) begin
              pool_st[idx] = BST_ALLOC;
            end
          end
        end
        default: begin
          if (!blk_in_use(idx)) o.status = STAT_NOT_IN_USE;
          else if (pool_cnt[idx] == 8'd0) o.status = STAT_COUNT_ERR;
        end
      endcase
    end
    if (idx >= 0) begin
      o.block_index = idx[IDX_W-1:0];
      if (blk_in_use(idx)) begin
        o.block_size = pool_sz[idx];
        o.handle_valid = pool_cnt[idx] != 8'd0;
      end
    end
    o.active_blocks = pool_active[TOTAL_W-1:0];
    o.peak_blocks = pool_peak[TOTAL_W-1:0];
    o.free_blocks = (pool_active >= NBLK) ? '0 : TOTAL_W'(NBLK - pool_active);
    return o;
  endfunction

  task automatic check_result(out_t want, out_t got);
    string diffs;
    diffs = "";
    if (got.status !== want.status)
      diffs = {diffs, $sformatf(" status %0d/%0d", want.status, got.status)};
    if (got.result_handle !== want.result_handle)
      diffs = {diffs, $sformatf(" handle %h/%h", want.result_handle, got.result_handle)};
    if (got.block_index !== want.block_index)
      diffs = {diffs, $sformatf(" index %0d/%0d", want.block_index, got.block_index)};
    if (got.block_size !== want.block_size)
      diffs = {diffs, $sformatf(" size %0d/%0d", want.block_size, got.block_size)};
    if (got.handle_valid !== want.handle_valid)
      diffs = {diffs, $sformatf(" valid %0b/%0b", want.handle_valid, got.handle_valid)};
    if (got.active_blocks !== want.active_blocks)
      diffs = {diffs, $sformatf(" active %0d/%0d", want.active_blocks, got.active_blocks)};
    if (got.peak_blocks !== want.peak_blocks)
      diffs = {diffs, $sformatf(" peak %0d/%0d", want.peak_blocks, got.peak_blocks)};
    if (got.free_blocks !== want.free_blocks)
      diffs = {diffs, $sformatf(" free %0d/%0d", want.free_blocks, got.free_blocks)};
    if (diffs != "") begin
      err_n++;
      if (err_n <= 10)
        $display("[%0t] result %0d mismatch (expected/actual):%s", $realtime, n_out, diffs);
    end
  endtask

  always @(posedge clk) begin : mon
    out_t want;
    cyc_n <= cyc_n + 1;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pend_q.size() == 0) begin
          err_n++;
          if (err_n <= 10) $display("[%0t] result with no request pending", $realtime);
        end else begin
          want = pend_q.pop_front();
          stat_seen[want.status]++;
          check_result(want, out_data);
        end
        n_out++;
      end
      if (in_valid && in_ready) begin
        pend_q.push_back(pool_apply(in_data));
        n_in++;
      end
    end
  end

  always @(posedge clk) begin
    if (cyc_n >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cyc_n, pend_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // advance to the next request once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && !hold_rx && ($urandom_range(99) >= recv_idle);
  end

  // hold the result channel long enough to back up the input
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_rx <= 1'b1;
    repeat (120) @(negedge clk);
    hold_rx <= 1'b0;
  end

  task automatic gen_alloc(int sz);
    int i;
    bit done;
    done = 1'b0;
    req_q.push_back(mk_req(KIND_ALLOC, sz[15:0], $urandom));
    if (sz >= 1 && sz <= BYTES) begin
      for (i = 0; i < NBLK; i++) begin
        if (!done && gen_cnt[i] == 0) begin
          gen_cnt[i] = 1;
          done = 1'b1;
        end
      end
    end
  endtask

  task automatic gen_op(kind_t k, int idx);
    req_q.push_back(mk_req(k, 16'($urandom), mk_handle(idx)));
    if (k == KIND_ACQUIRE && gen_cnt[idx] > 0 && gen_cnt[idx] < CNT_MAX) gen_cnt[idx]++;
    if (k == KIND_RELEASE && gen_cnt[idx] > 0) gen_cnt[idx]--;
  endtask

  function automatic int pick_live();
    int s;
    int i;
    s = $urandom_range(NBLK - 1);
    for (i = 0; i < NBLK; i++) begin
      if (gen_cnt[(s + i) % NBLK] > 0) return (s + i) % NBLK;
    end
    return -1;
  endfunction

  function automatic int count_live();
    int i;
    int n;
    n = 0;
    for (i = 0; i < NBLK; i++) if (gen_cnt[i] > 0) n++;
    return n;
  endfunction

  // fill the pool to exhaustion, then drain it, over and over
  task automatic gen_random(int n);
    int j;
    int r;
    int live;
    int pick;
    int sz;
    kind_t k;
    for (j = 0; j < n; j++) begin
      live = count_live();
      if (fill_mode && live == NBLK && $urandom_range(9) == 0) fill_mode = 1'b0;
      if (!fill_mode && live <= 4) fill_mode = 1'b1;
      r = $urandom_range(99);
      pick = pick_live();
      if (pick < 0 || $urandom_range(9) == 0) pick = $urandom_range(NBLK - 1);
      if (!fill_mode) r = (r < 8) ? r * 70 / 8 : (r < 18) ? r - 8 + 70 :
                          (r < 78) ? 80 + (r - 18) * 8 / 60 : (r < 90) ? 88 + (r - 78) / 2 : r;
      if (r < 70) begin
        sz = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 1 : BYTES) : $urandom_range(BYTES, 1);
        gen_alloc(sz);
      end else if (r < 80) begin
        gen_op(KIND_ACQUIRE, pick);
      end else if (r < 88) begin
        gen_op(KIND_RELEASE, pick);
      end else if (r < 94) begin
        gen_op(KIND_LOOKUP, pick);
      end else begin
        k = kind_t'($urandom_range(3, 1));
        case ($urandom_range(4))
          0: gen_alloc(($urandom_range(3) == 0) ? 0 : $urandom_range(65535, BYTES + 1));
          1: req_q.push_back(mk_req(k, 16'($urandom), $urandom));
          2: req_q.push_back(mk_req(k, 16'($urandom), 32'h0));
          3: req_q.push_back(mk_req(k, 16'($urandom), mk_handle($urandom_range(65535, NBLK))));
          default: req_q.push_back(mk_req(k, 16'($urandom),
                                          mk_handle(pick) ^ (32'h1 << $urandom_range(31, 16))));
        endcase
      end
    end
  endtask

  task automatic drain_all();
    while (req_q.size() != 0 || in_valid || pend_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : main
    int i;
    for (i = 0; i < NBLK; i++) begin
      pool_st[i] = BST_FREE;
      pool_cnt[i] = 8'd0;
      pool_sz[i] = SIZE_W'(BYTES);
      gen_cnt[i] = 0;
    end
    for (i = 0; i < 6; i++) stat_seen[i] = 0;
    pool_active = 0;
    pool_peak = 0;
    fill_mode = 1'b1;
    send_idle = 7;
    recv_idle = 71;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    req_q.push_back(mk_req(KIND_LOOKUP, 16'h0, 32'h0));
    gen_alloc(0);
    gen_alloc(BYTES + 1);
    gen_alloc(65535);
    gen_alloc(1);
    gen_alloc(BYTES);
    gen_op(KIND_ACQUIRE, 0);
    gen_op(KIND_ACQUIRE, 0);
    gen_op(KIND_LOOKUP, 0);
    repeat (4) gen_op(KIND_RELEASE, 0);
    gen_op(KIND_ACQUIRE, 0);
    gen_op(KIND_LOOKUP, 0);
    req_q.push_back(mk_req(KIND_ACQUIRE, 16'hFFFF, 32'h0000_0001));
    req_q.push_back(mk_req(KIND_RELEASE, 16'h0, mk_handle(NBLK)));
    req_q.push_back(mk_req(KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF));
    gen_op(KIND_LOOKUP, NBLK - 1);
    gen_op(KIND_RELEASE, 1);
    gen_alloc(128);
    gen_op(KIND_LOOKUP, 0);
    // drive block 0 up to its count ceiling and past it
    repeat (CNT_MAX + 1) gen_op(KIND_ACQUIRE, 0);
    gen_op(KIND_LOOKUP, 0);
    gen_random(57);
    drain_all();

    send_idle = 71;
    recv_idle = 7;
    gen_random(57);
    drain_all();

    send_idle = 0;
    recv_idle = 0;
    hold_go = 1'b1;
    gen_random(57);
    drain_all();

    repeat (20) @(posedge clk);
    $display("%0d requests, %0d results; ok %0d, bad size %0d, exhausted %0d,", n_in, n_out,
             stat_seen[STAT_OK], stat_seen[STAT_BAD_SIZE], stat_seen[STAT_EXHAUSTED]);
    $display("bad handle %0d, not in use %0d, count error %0d; peak %0d, mismatches %0d",
             stat_seen[STAT_BAD_HANDLE], stat_seen[STAT_NOT_IN_USE], stat_seen[STAT_COUNT_ERR],
             pool_peak, err_n);
    if (err_n == 0 && pend_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
sv/rbpm_pkg.sv
sv/rbpm_ram.sv
sv/rbpm_free_search.sv
sv/refcounted_block_pool_manager.sv
tb/tb_refcounted_block_pool_manager.sv
